[rtl/crcfd_pkg.sv]
// shared types, constants and the crc-32 byte step of the frame deframer
package crcfd_pkg;

    // header layout
    localparam int HDR_BYTES = 20;
    localparam int CRC_SPAN  = 16;
    localparam int FLAGS_AT  = 6;
    localparam int ID_AT     = 8;
    localparam int LEN_AT    = 12;

    // declared payload length width
    localparam int LENGTH_BITS = 24;
    localparam logic [31:0] LEN_MASK = 32'hFFFF_FFFF >> (32 - LENGTH_BITS);

    // header byte counter and store
    localparam int CNT_BITS = 5;

    // result queue
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_BITS   = 2;
    localparam int QCNT_BITS   = 3;

    // crc-32, reflected
    localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;
    localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;

    // configuration register reset values
    localparam logic [31:0] MAGIC_RESET   = 32'h4652_4C59;
    localparam logic [7:0]  VERSION_RESET = 8'd1;
    localparam logic [63:0] TYPES_RESET   = 64'h0000_0000_03FF_FFFF;
    localparam logic [LENGTH_BITS-1:0] MAXLEN_RESET = LENGTH_BITS'(8388608);

    // configuration register indexes
    typedef enum logic [1:0] {
        REG_MAGIC   = 2'd0,
        REG_VERSION = 2'd1,
        REG_TYPES   = 2'd2,
        REG_MAXLEN  = 2'd3
    } reg_index_t;

    // result kinds
    typedef enum logic [1:0] {
        KIND_PAYLOAD = 2'd0,
        KIND_EMPTY   = 2'd1,
        KIND_ERROR   = 2'd2
    } kind_t;

    // parser phases
    typedef enum logic [2:0] {
        PH_HEADER  = 3'b001,
        PH_PAYLOAD = 3'b010,
        PH_ERROR   = 3'b100
    } phase_t;

    // one result beat
    typedef struct packed {
        kind_t                  kind;
        logic [7:0]             payload_byte;
        logic [7:0]             frame_type;
        logic [31:0]            request_id;
        logic [LENGTH_BITS-1:0] frame_length;
        logic                   last_of_frame;
    } result_t;

    // front to queue handoff
    typedef struct packed {
        logic    valid;
        result_t res;
    } push_t;

    // one byte of the crc update
    function automatic logic [31:0] crc_byte(input logic [31:0] c, input logic [7:0] b);
        logic [31:0] r;
        r = c ^ {24'd0, b};
        for (int k = 0; k < 8; k++) begin
            r = r[0] ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
        end
        return r;
    endfunction

endpackage

[rtl/crcfd_ifs.sv]
// input and result channel interfaces of the frame deframer
interface crcfd_in_if;
    logic       valid;
    logic       ready;
    logic       action;
    logic [7:0] data_byte;

    modport source (output valid, output action, output data_byte, input ready);
    modport sink (input valid, input action, input data_byte, output ready);
endinterface

interface crcfd_out_if;
    logic                             valid;
    logic                             ready;
    logic [1:0]                       kind;
    logic [7:0]                       payload_byte;
    logic [7:0]                       frame_type;
    logic [31:0]                      request_id;
    logic [crcfd_pkg::LENGTH_BITS-1:0] frame_length;
    logic                             last_of_frame;

    modport source (output valid, output kind, output payload_byte, output frame_type,
                    output request_id, output frame_length, output last_of_frame,
                    input ready);
    modport sink (input valid, input kind, input payload_byte, input frame_type,
                  input request_id, input frame_length, input last_of_frame,
                  output ready);
endinterface

[rtl/crcfd_front.sv]
// front part: accepts beats, collects and checks the header, classifies results
module crcfd_front (
    input  logic                clk,
    input  logic                rst_n,
    crcfd_in_if.sink            rx,
    input  logic                cfg_we,
    input  logic [1:0]          cfg_index,
    input  logic [63:0]         cfg_data,
    input  logic                space,
    output crcfd_pkg::push_t    push
);

    localparam int LB = crcfd_pkg::LENGTH_BITS;

    // configuration registers
    logic [31:0]   magic_reg;
    logic [7:0]    version_reg;
    logic [63:0]   types_reg;
    logic [LB-1:0] maxlen_reg;

    // parse state
    crcfd_pkg::phase_t                  phase_reg, phase_next;
    logic [crcfd_pkg::CNT_BITS-1:0]     cnt_reg, cnt_next;
    logic [31:0]                        crc_reg, crc_next;
    logic [7:0]                         type_reg, type_next;
    logic [31:0]                        id_reg, id_next;
    logic [LB-1:0]                      len_reg, len_next;
    logic [LB-1:0]                      left_reg, left_next;

    // header bytes 0..18, the last one is taken straight from the beat
    logic [7:0] hdr_reg [0:crcfd_pkg::HDR_BYTES-2];

    logic        fire;
    logic [7:0]  b;
    logic [31:0] h_magic, h_id, h_len, h_crc;
    logic [15:0] h_flags;
    logic [7:0]  h_type;
    logic        hdr_ok;
    logic        last;

    assign rx.ready = space;
    assign fire     = rx.valid && space;
    assign b        = rx.data_byte;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            magic_reg   <= crcfd_pkg::MAGIC_RESET;
            version_reg <= crcfd_pkg::VERSION_RESET;
            types_reg   <= crcfd_pkg::TYPES_RESET;
            maxlen_reg  <= crcfd_pkg::MAXLEN_RESET;
        end
        else if (cfg_we) begin
            case (crcfd_pkg::reg_index_t'(cfg_index))
                crcfd_pkg::REG_MAGIC:   magic_reg   <= cfg_data[31:0];
                crcfd_pkg::REG_VERSION: version_reg <= cfg_data[7:0];
                crcfd_pkg::REG_TYPES:   types_reg   <= cfg_data;
                crcfd_pkg::REG_MAXLEN:  maxlen_reg  <= cfg_data[LB-1:0];
                default: ;
            endcase
        end
    end

    // header store, written at the byte counter
    always_ff @(posedge clk) begin
        if (fire && !rx.action && (phase_reg == crcfd_pkg::PH_HEADER)
            && (cnt_reg != crcfd_pkg::CNT_BITS'(crcfd_pkg::HDR_BYTES - 1))) begin
            hdr_reg[cnt_reg] <= b;
        end
    end

    // header fields
    assign h_magic = {hdr_reg[0], hdr_reg[1], hdr_reg[2], hdr_reg[3]};
    assign h_type  = hdr_reg[5];
    assign h_flags = {hdr_reg[crcfd_pkg::FLAGS_AT], hdr_reg[crcfd_pkg::FLAGS_AT + 1]};
    assign h_id    = {hdr_reg[crcfd_pkg::ID_AT], hdr_reg[crcfd_pkg::ID_AT + 1],
                      hdr_reg[crcfd_pkg::ID_AT + 2], hdr_reg[crcfd_pkg::ID_AT + 3]};
    assign h_len   = {hdr_reg[crcfd_pkg::LEN_AT], hdr_reg[crcfd_pkg::LEN_AT + 1],
                      hdr_reg[crcfd_pkg::LEN_AT + 2], hdr_reg[crcfd_pkg::LEN_AT + 3]};
    assign h_crc   = {hdr_reg[crcfd_pkg::CRC_SPAN], hdr_reg[crcfd_pkg::CRC_SPAN + 1],
                      hdr_reg[crcfd_pkg::CRC_SPAN + 2], b};

    // header checks at the last header byte
    always_comb begin
        hdr_ok = 1'b1;
        if (h_magic != magic_reg) hdr_ok = 1'b0;
        if (hdr_reg[4] != version_reg) hdr_ok = 1'b0;
        if (h_flags != 16'd0) hdr_ok = 1'b0;
        if (h_id == 32'd0) hdr_ok = 1'b0;
        if (h_type[7:6] != 2'd0 || !types_reg[h_type[5:0]]) hdr_ok = 1'b0;
        if (h_len > 32'(maxlen_reg) || h_len > crcfd_pkg::LEN_MASK) hdr_ok = 1'b0;
        if (h_crc != ~crc_reg) hdr_ok = 1'b0;
    end

    // parser next state and result classification
    always_comb begin
        phase_next = phase_reg;
        cnt_next   = cnt_reg;
        crc_next   = crc_reg;
        type_next  = type_reg;
        id_next    = id_reg;
        len_next   = len_reg;
        left_next  = left_reg;
        push       = '0;
        last       = 1'b0;

        if (fire) begin
            if (rx.action) begin
                // restart drops any partial frame
                phase_next = crcfd_pkg::PH_HEADER;
                cnt_next   = '0;
                crc_next   = crcfd_pkg::CRC_INIT;
                type_next  = '0;
                id_next    = '0;
                len_next   = '0;
                left_next  = '0;
            end
            else begin
                case (phase_reg)
                    crcfd_pkg::PH_HEADER: begin
                        if (cnt_reg < crcfd_pkg::CNT_BITS'(crcfd_pkg::CRC_SPAN)) begin
                            crc_next = crcfd_pkg::crc_byte(crc_reg, b);
                        end
                        if (cnt_reg == crcfd_pkg::CNT_BITS'(crcfd_pkg::HDR_BYTES - 1)) begin
                            cnt_next = '0;
                            if (!hdr_ok) begin
                                phase_next       = crcfd_pkg::PH_ERROR;
                                push.valid       = 1'b1;
                                push.res.kind    = crcfd_pkg::KIND_ERROR;
                            end
                            else if (h_len[LB-1:0] == '0) begin
                                // empty frame completes at once
                                push.valid              = 1'b1;
                                push.res.kind           = crcfd_pkg::KIND_EMPTY;
                                push.res.frame_type     = h_type;
                                push.res.request_id     = h_id;
                                push.res.last_of_frame  = 1'b1;
                                crc_next                = crcfd_pkg::CRC_INIT;
                                type_next               = '0;
                                id_next                 = '0;
                                len_next                = '0;
                                left_next               = '0;
                            end
                            else begin
                                phase_next = crcfd_pkg::PH_PAYLOAD;
                                type_next  = h_type;
                                id_next    = h_id;
                                len_next   = h_len[LB-1:0];
                                left_next  = h_len[LB-1:0];
                            end
                        end
                        else begin
                            cnt_next = cnt_reg + 1'b1;
                        end
                    end
                    crcfd_pkg::PH_PAYLOAD: begin
                        if (left_reg == '0) begin
                            phase_next = crcfd_pkg::PH_HEADER;
                            cnt_next   = '0;
                            crc_next   = crcfd_pkg::CRC_INIT;
                            type_next  = '0;
                            id_next    = '0;
                            len_next   = '0;
                        end
                        else begin
                            last                   = (left_reg == LB'(1));
                            left_next              = left_reg - 1'b1;
                            push.valid             = 1'b1;
                            push.res.kind          = crcfd_pkg::KIND_PAYLOAD;
                            push.res.payload_byte  = b;
                            push.res.frame_type    = type_reg;
                            push.res.request_id    = id_reg;
                            push.res.frame_length  = len_reg;
                            push.res.last_of_frame = last;
                            if (last) begin
                                phase_next = crcfd_pkg::PH_HEADER;
                                cnt_next   = '0;
                                crc_next   = crcfd_pkg::CRC_INIT;
                                type_next  = '0;
                                id_next    = '0;
                                len_next   = '0;
                            end
                        end
                    end
                    default: ;
                endcase
            end
        end
    end

    // parse state registers
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            phase_reg <= crcfd_pkg::PH_HEADER;
            cnt_reg   <= '0;
            crc_reg   <= crcfd_pkg::CRC_INIT;
            type_reg  <= '0;
            id_reg    <= '0;
            len_reg   <= '0;
            left_reg  <= '0;
        end
        else begin
            phase_reg <= phase_next;
            cnt_reg   <= cnt_next;
            crc_reg   <= crc_next;
            type_reg  <= type_next;
            id_reg    <= id_next;
            len_reg   <= len_next;
            left_reg  <= left_next;
        end
    end

endmodule

[rtl/crcfd_queue.sv]
// back part: result queue that decouples the parser from the receiver
module crcfd_queue (
    input  logic             clk,
    input  logic             rst_n,
    input  crcfd_pkg::push_t push,
    output logic             space,
    crcfd_out_if.source      tx
);

    localparam int QD = crcfd_pkg::QUEUE_DEPTH;
    localparam int PB = crcfd_pkg::QPTR_BITS;
    localparam int CB = crcfd_pkg::QCNT_BITS;

    crcfd_pkg::result_t mem_reg [0:QD-1];
    logic [PB-1:0] wr_reg, wr_next;
    logic [PB-1:0] rd_reg, rd_next;
    logic [CB-1:0] cnt_reg, cnt_next;
    logic          pop;
    crcfd_pkg::result_t head;

    assign space = (cnt_reg != CB'(QD));
    assign pop   = tx.valid && tx.ready;

    // pointer and fill count update
    always_comb begin
        wr_next  = wr_reg;
        rd_next  = rd_reg;
        cnt_next = cnt_reg;
        if (push.valid) begin
            wr_next = wr_reg + 1'b1;
        end
        if (pop) begin
            rd_next = rd_reg + 1'b1;
        end
        case ({push.valid, pop})
            2'b10:   cnt_next = cnt_reg + 1'b1;
            2'b01:   cnt_next = cnt_reg - 1'b1;
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

    // entry storage
    always_ff @(posedge clk) begin
        if (push.valid) begin
            mem_reg[wr_reg] <= push.res;
        end
    end

    // head entry drives the result channel
    assign head             = mem_reg[rd_reg];
    assign tx.valid         = (cnt_reg != '0);
    assign tx.kind          = head.kind;
    assign tx.payload_byte  = head.payload_byte;
    assign tx.frame_type    = head.frame_type;
    assign tx.request_id    = head.request_id;
    assign tx.frame_length  = head.frame_length;
    assign tx.last_of_frame = head.last_of_frame;

endmodule

[rtl/crc_checked_frame_deframer.sv]
// top level of the crc checked frame deframer
//
// rx carries one beat per stream byte (action 0) or a parser restart
// (action 1). each frame opens with a 20-byte big-endian header whose
// crc-32 over bytes 0-15 sits in bytes 16-19; after the 20th byte the
// header is checked against the configuration registers.
// tx carries results: one beat per payload byte, one empty-frame beat for
// a zero-length frame, or one error beat after which bytes are dropped
// until a restart.
// a result is pushed to the queue when its rx beat is accepted and reaches
// tx behind older results; rx takes one beat every cycle while the queue
// has space. a 4-entry result queue sits between parser and tx: when the
// receiver stalls the queue fills and rx.ready drops only once it is full.
// reset restores the register defaults, puts the parser at the start of a
// header and empties the queue. configuration writes (cfg_we, cfg_index,
// cfg_data) take effect at once and are meant for an idle block.
module crc_checked_frame_deframer (
    input  logic        clk,
    input  logic        rst_n,
    crcfd_in_if.sink    rx,
    crcfd_out_if.source tx,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [63:0] cfg_data
);

    crcfd_pkg::push_t push;
    logic             space;

    // parser and classifier
    crcfd_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .rx        (rx),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .space     (space),
        .push      (push)
    );

    // result queue and output
    crcfd_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .space (space),
        .tx    (tx)
    );

endmodule

[bench/tb_crc_checked_frame_deframer.sv]
`timescale 1ns / 1ps
// self-checking testbench of the crc checked frame deframer with its frame scoreboard

// expected results of the deframer, worked out beat by beat
class deframer_scoreboard;
    // register copies
    logic [31:0]                       magic_cfg;
    logic [7:0]                        version_cfg;
    logic [63:0]                       type_mask_cfg;
    logic [crcfd_pkg::LENGTH_BITS-1:0] max_len_cfg;

    // parse state copies
    crcfd_pkg::phase_t                 stage;
    int                                hdr_cnt;
    logic [7:0]                        hdr_bytes [crcfd_pkg::HDR_BYTES];
    logic [31:0]                       crc_acc;
    logic [7:0]                        cur_type;
    logic [31:0]                       cur_id;
    logic [crcfd_pkg::LENGTH_BITS-1:0] cur_len;
    logic [crcfd_pkg::LENGTH_BITS-1:0] remain;

    crcfd_pkg::result_t                pending_results [$];
    int                                errors;

    function new();
        magic_cfg     = crcfd_pkg::MAGIC_RESET;
        version_cfg   = crcfd_pkg::VERSION_RESET;
        type_mask_cfg = crcfd_pkg::TYPES_RESET;
        max_len_cfg   = crcfd_pkg::MAXLEN_RESET;
        errors        = 0;
        restart_parse();
    endfunction

    // reflected crc-32, one data bit per step
    static function logic [31:0] crc_step(logic [31:0] c, logic [7:0] b);
        logic [31:0] acc;
        acc = c;
        for (int k = 0; k < 8; k++)
        begin
            if (acc[0] ^ b[k])
                acc = (acc >> 1) ^ 32'hEDB8_8320;
            else
                acc = acc >> 1;
        end
        return acc;
    endfunction

    function void restart_parse();
        stage    = crcfd_pkg::PH_HEADER;
        hdr_cnt  = 0;
        crc_acc  = 32'hFFFF_FFFF;
        cur_type = '0;
        cur_id   = '0;
        cur_len  = '0;
        remain   = '0;
    endfunction

    function void write_reg(crcfd_pkg::reg_index_t idx, logic [63:0] v);
        case (idx)
            crcfd_pkg::REG_MAGIC:   magic_cfg = v[31:0];
            crcfd_pkg::REG_VERSION: version_cfg = v[7:0];
            crcfd_pkg::REG_TYPES:   type_mask_cfg = v;
            crcfd_pkg::REG_MAXLEN:  max_len_cfg = v[crcfd_pkg::LENGTH_BITS-1:0];
            default:                ;
        endcase
    endfunction

    function logic [31:0] hdr_word(int at);
        return {hdr_bytes[at], hdr_bytes[at+1], hdr_bytes[at+2], hdr_bytes[at+3]};
    endfunction

    // all header checks done after the last header byte
    function bit header_good();
        logic [31:0] len;
        logic [7:0]  ty;
        len = hdr_word(crcfd_pkg::LEN_AT);
        ty  = hdr_bytes[5];
        if (hdr_word(0) != magic_cfg) return 1'b0;
        if (hdr_bytes[4] != version_cfg) return 1'b0;
        if ({hdr_bytes[crcfd_pkg::FLAGS_AT], hdr_bytes[crcfd_pkg::FLAGS_AT+1]} != 16'h0000)
            return 1'b0;
        if (hdr_word(crcfd_pkg::ID_AT) == 32'd0) return 1'b0;
        if (ty >= 8'd64 || !type_mask_cfg[ty[5:0]]) return 1'b0;
        if (len > 32'(max_len_cfg) || len > crcfd_pkg::LEN_MASK) return 1'b0;
        if (hdr_word(crcfd_pkg::CRC_SPAN) != ~crc_acc) return 1'b0;
        return 1'b1;
    endfunction

    // one accepted input beat
    function void note_beat(logic act, logic [7:0] b);
        crcfd_pkg::result_t r;
        logic [31:0]        word;
        r = '0;
        if (act)
        begin
            restart_parse();
            return;
        end
        case (stage)
            crcfd_pkg::PH_HEADER:
            begin
                if (hdr_cnt >= crcfd_pkg::HDR_BYTES) hdr_cnt = 0;
                hdr_bytes[hdr_cnt] = b;
                if (hdr_cnt < crcfd_pkg::CRC_SPAN) crc_acc = crc_step(crc_acc, b);
                hdr_cnt++;
                if (hdr_cnt == crcfd_pkg::HDR_BYTES)
                begin
                    hdr_cnt = 0;
                    if (!header_good())
                    begin
                        stage  = crcfd_pkg::PH_ERROR;
                        r.kind = crcfd_pkg::KIND_ERROR;
                        pending_results.push_back(r);
                    end
                    else
                    begin
                        word     = hdr_word(crcfd_pkg::LEN_AT);
                        cur_type = hdr_bytes[5];
                        cur_id   = hdr_word(crcfd_pkg::ID_AT);
                        cur_len  = word[crcfd_pkg::LENGTH_BITS-1:0];
                        remain   = cur_len;
                        if (remain == '0)
                        begin
                            r.kind          = crcfd_pkg::KIND_EMPTY;
                            r.frame_type    = cur_type;
                            r.request_id    = cur_id;
                            r.frame_length  = cur_len;
                            r.last_of_frame = 1'b1;
                            pending_results.push_back(r);
                            restart_parse();
                        end
                        else
                            stage = crcfd_pkg::PH_PAYLOAD;
                    end
                end
            end
            crcfd_pkg::PH_PAYLOAD:
            begin
                if (remain == '0)
                    restart_parse();
                else
                begin
                    remain          = remain - 1'b1;
                    r.kind          = crcfd_pkg::KIND_PAYLOAD;
                    r.payload_byte  = b;
                    r.frame_type    = cur_type;
                    r.request_id    = cur_id;
                    r.frame_length  = cur_len;
                    r.last_of_frame = (remain == '0);
                    pending_results.push_back(r);
                    if (remain == '0) restart_parse();
                end
            end
            // error phase: byte dropped
            default: ;
        endcase
    endfunction

    task report(string what);
        errors++;
        if (errors <= 100) $display("[%0t] mismatch: %s", $time, what);
    endtask

    // one accepted result beat against the oldest expectation
    task check_result(crcfd_pkg::result_t got);
        crcfd_pkg::result_t want;
        if (pending_results.size() == 0)
        begin
            report($sformatf("result with nothing expected, kind %0d", got.kind));
            return;
        end
        want = pending_results.pop_front();
        if (got.kind !== want.kind)
            report($sformatf("kind %0d, want %0d", got.kind, want.kind));
        if (got.payload_byte !== want.payload_byte)
            report($sformatf("payload_byte %h, want %h", got.payload_byte, want.payload_byte));
        if (got.frame_type !== want.frame_type)
            report($sformatf("frame_type %h, want %h", got.frame_type, want.frame_type));
        if (got.request_id !== want.request_id)
            report($sformatf("request_id %h, want %h", got.request_id, want.request_id));
        if (got.frame_length !== want.frame_length)
            report($sformatf("frame_length %h, want %h", got.frame_length, want.frame_length));
        if (got.last_of_frame !== want.last_of_frame)
            report($sformatf("last_of_frame %b, want %b", got.last_of_frame, want.last_of_frame));
    endtask
endclass

module tb_crc_checked_frame_deframer;

    localparam int HOLD_CYCLES = 60;

    // ways a header is broken on purpose
    typedef enum logic [2:0] {
        FAULT_NONE    = 3'd0,
        FAULT_MAGIC   = 3'd1,
        FAULT_VERSION = 3'd2,
        FAULT_FLAGS   = 3'd3,
        FAULT_ID      = 3'd4,
        FAULT_TYPE    = 3'd5,
        FAULT_LENGTH  = 3'd6,
        FAULT_CRC     = 3'd7
    } header_fault_t;

    // one input beat waiting to be sent
    typedef struct packed {
        logic       act;
        logic [7:0] b;
    } stream_beat_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [1:0]  cfg_index;
    logic [63:0] cfg_data;

    crcfd_in_if  rx();
    crcfd_out_if tx();

    deframer_scoreboard sb = new();

    stream_beat_t beat_q [$];
    int           burst_left = 0;
    bit           steady_feed = 1'b0;
    int           hold_asks = 0;

    crc_checked_frame_deframer dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .rx        (rx),
        .tx        (tx),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // run limit
    initial
    begin
        #2_000_000;
        $display("Verification failed");
        $finish;
    end

    // watch both channels; results first, they always belong to older beats
    always @(posedge clk)
    begin : watch
        crcfd_pkg::result_t seen;
        if (rst_n)
        begin
            if (tx.valid && tx.ready)
            begin
                seen.kind          = crcfd_pkg::kind_t'(tx.kind);
                seen.payload_byte  = tx.payload_byte;
                seen.frame_type    = tx.frame_type;
                seen.request_id    = tx.request_id;
                seen.frame_length  = tx.frame_length;
                seen.last_of_frame = tx.last_of_frame;
                sb.check_result(seen);
            end
            if (rx.valid && rx.ready)
                sb.note_beat(rx.action, rx.data_byte);
        end
    end

    // receiver: stall styles that change now and then, plus the long hold-off
    initial
    begin : receiver
        int style;
        int span;
        int hold_seen;
        style     = 0;
        span      = 0;
        hold_seen = 0;
        tx.ready  = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_asks != hold_seen)
            begin
                hold_seen = hold_asks;
                tx.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            if (span == 0)
            begin
                style = $urandom_range(0, 3);
                span  = $urandom_range(16, 96);
            end
            span--;
            case (style)
                0:       tx.ready <= 1'b1;
                1:       tx.ready <= 1'($urandom_range(0, 1));
                2:       tx.ready <= (span % 4) != 0;
                default: tx.ready <= ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    function automatic void add_byte(logic [7:0] b);
        beat_q.push_back({1'b0, b});
    endfunction

    function automatic void add_restart();
        beat_q.push_back({1'b1, 8'($urandom)});
    endfunction

    // a type the current mask accepts, or one it rejects
    function automatic logic [7:0] pick_type(bit allowed);
        int t;
        for (int tries = 0; tries < 200; tries++)
        begin
            t = allowed ? $urandom_range(0, 63) : $urandom_range(0, 127);
            if (t >= 64)
            begin
                if (!allowed) return 8'($urandom_range(64, 255));
            end
            else if (sb.type_mask_cfg[t] == allowed)
                return 8'(t);
        end
        return allowed ? 8'd0 : 8'd255;
    endfunction

    function automatic int short_len();
        return ($urandom_range(0, 9) < 8) ? $urandom_range(0, 6) : $urandom_range(7, 24);
    endfunction

    // header plus payload, optionally broken, optionally cut short by a restart
    function automatic void add_frame(header_fault_t fault, int plen, int stop_at = -1,
                                      int force_type = -1, logic [31:0] force_id = '0);
        logic [7:0]  hdr [crcfd_pkg::HDR_BYTES];
        logic [31:0] magic;
        logic [31:0] id;
        logic [31:0] len;
        logic [31:0] crc;
        logic [7:0]  version;
        logic [7:0]  ftype;
        logic [15:0] flags;
        bit          doomed;
        if (fault == FAULT_NONE && plen > sb.max_len_cfg) plen = int'(sb.max_len_cfg);
        magic   = sb.magic_cfg;
        version = sb.version_cfg;
        ftype   = (force_type >= 0) ? 8'(force_type) : pick_type(1'b1);
        flags   = '0;
        id      = $urandom;
        if ($urandom_range(0, 7) == 0) id = 32'd1;
        if (id == 32'd0) id = 32'hFFFF_FFFF;
        if (force_id != '0) id = force_id;
        len = 32'(plen);
        case (fault)
            FAULT_MAGIC:   magic = magic ^ (32'd1 << $urandom_range(0, 31));
            FAULT_VERSION: version = version ^ 8'($urandom_range(1, 255));
            FAULT_FLAGS:   flags = 16'($urandom_range(1, 65535));
            FAULT_ID:      id = '0;
            FAULT_TYPE:    ftype = pick_type(1'b0);
            FAULT_LENGTH:
            begin
                if ($urandom_range(0, 1) != 0)
                    len = {8'($urandom_range(1, 255)), 24'($urandom)};
                else
                    len = 32'(sb.max_len_cfg) + 32'($urandom_range(1, 64));
            end
            default: ;
        endcase
        {hdr[0], hdr[1], hdr[2], hdr[3]}     = magic;
        hdr[4]                               = version;
        hdr[5]                               = ftype;
        {hdr[6], hdr[7]}                     = flags;
        {hdr[8], hdr[9], hdr[10], hdr[11]}   = id;
        {hdr[12], hdr[13], hdr[14], hdr[15]} = len;
        crc = 32'hFFFF_FFFF;
        for (int i = 0; i < crcfd_pkg::CRC_SPAN; i++)
            crc = sb.crc_step(crc, hdr[i]);
        crc = ~crc;
        if (fault == FAULT_CRC) crc = crc ^ (32'd1 << $urandom_range(0, 31));
        {hdr[16], hdr[17], hdr[18], hdr[19]} = crc;
        doomed = (fault != FAULT_NONE) || ftype >= 8'd64 || !sb.type_mask_cfg[ftype[5:0]];

        // payload bytes of a rejected frame are dropped by the block
        for (int i = 0; i < crcfd_pkg::HDR_BYTES + plen; i++)
        begin
            if (i == stop_at)
            begin
                add_restart();
                return;
            end
            add_byte(i < crcfd_pkg::HDR_BYTES ? hdr[i] : 8'($urandom));
        end
        if (doomed) add_restart();
    endfunction

    // send the queued beats in bursts, with random gaps unless steady_feed is set
    task automatic play_stream();
        stream_beat_t bt;
        while (beat_q.size() > 0)
        begin
            if (burst_left == 0)
            begin
                burst_left = $urandom_range(1, 24);
                if (!steady_feed && $urandom_range(0, 3) != 0)
                begin
                    rx.valid     <= 1'b0;
                    rx.data_byte <= 8'($urandom);
                    repeat ($urandom_range(1, 6)) @(posedge clk);
                end
            end
            bt = beat_q.pop_front();
            rx.valid     <= 1'b1;
            rx.action    <= bt.act;
            rx.data_byte <= bt.b;
            @(posedge clk);
            while (!rx.ready) @(posedge clk);
            burst_left--;
        end
        rx.valid <= 1'b0;
        @(posedge clk);
    endtask

    // mostly good frames, mixed with broken headers, cut frames and noise
    task automatic run_random(int budget);
        int pick;
        int plen;
        header_fault_t fault;
        while (beat_q.size() < budget)
        begin
            pick = $urandom_range(0, 99);
            plen = short_len();
            if (pick < 55)
                add_frame(FAULT_NONE, plen);
            else if (pick < 80)
            begin
                fault = header_fault_t'($urandom_range(1, 7));
                add_frame(fault, plen);
            end
            else if (pick < 90)
                add_frame(FAULT_NONE, plen,
                          $urandom_range(1, crcfd_pkg::HDR_BYTES + plen - 1));
            else
            begin
                repeat ($urandom_range(1, 30)) add_byte(8'($urandom));
                add_restart();
            end
            if ($urandom_range(0, 9) == 0) add_restart();
        end
        play_stream();
    endtask

    // wait until every expected result has come and the block is quiet
    task automatic settle();
        @(posedge clk);
        while (sb.pending_results.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // one register write, then the enable goes low again
    task automatic write_reg(crcfd_pkg::reg_index_t idx, logic [63:0] v);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= v;
        @(posedge clk);
        sb.write_reg(idx, v);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    // main sequence
    initial
    begin
        rst_n        = 1'b0;
        rx.valid     = 1'b0;
        rx.action    = 1'b0;
        rx.data_byte = 8'h00;
        cfg_we       = 1'b0;
        cfg_index    = crcfd_pkg::REG_MAGIC;
        cfg_data     = '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset values: restart inside a header, empty frame with top type and id
        add_frame(FAULT_NONE, 0, 7);
        add_frame(FAULT_NONE, 0, -1, 25, 32'hFFFF_FFFF);
        play_stream();
        run_random(60);
        settle();

        // version zero, every low type allowed, tight length limit, junk above widths
        write_reg(crcfd_pkg::REG_MAGIC, {32'($urandom), 32'($urandom)});
        write_reg(crcfd_pkg::REG_VERSION, {24'($urandom), 32'($urandom), 8'h00});
        write_reg(crcfd_pkg::REG_TYPES, '1);
        write_reg(crcfd_pkg::REG_MAXLEN, {8'($urandom), 32'($urandom), 24'd8});
        run_random(55);
        settle();

        // nothing passes: no type allowed, zero length limit
        write_reg(crcfd_pkg::REG_VERSION, 64'hFF);
        write_reg(crcfd_pkg::REG_TYPES, '0);
        write_reg(crcfd_pkg::REG_MAXLEN, '0);
        run_random(35);
        settle();

        // random setting, reset length limit, long receiver hold-off
        write_reg(crcfd_pkg::REG_MAGIC, 64'($urandom));
        write_reg(crcfd_pkg::REG_VERSION, 64'($urandom_range(0, 255)));
        write_reg(crcfd_pkg::REG_TYPES, {32'($urandom), 32'($urandom)});
        write_reg(crcfd_pkg::REG_MAXLEN, 64'(crcfd_pkg::MAXLEN_RESET));
        steady_feed = 1'b1;
        hold_asks++;
        add_frame(FAULT_NONE, 48);
        play_stream();
        steady_feed = 1'b0;
        run_random(55);
        settle();

        // reset-like setting with a moderate limit
        write_reg(crcfd_pkg::REG_MAGIC, 64'(crcfd_pkg::MAGIC_RESET));
        write_reg(crcfd_pkg::REG_VERSION, 64'(crcfd_pkg::VERSION_RESET));
        write_reg(crcfd_pkg::REG_TYPES, crcfd_pkg::TYPES_RESET);
        write_reg(crcfd_pkg::REG_MAXLEN, 64'($urandom_range(9, 200)));
        run_random(55);
        settle();
        repeat (8) @(posedge clk);

        if (sb.errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
